@@ hw/rtl/rps_pkg.sv @@
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types, constants and helpers of the resource placement scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

  // default table sizes
  localparam int NODE_COUNT_DEF = 16;
  localparam int TYPE_COUNT_DEF = 4;
  localparam int TASK_SLOTS_DEF = 16;

  // datapath widths
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 48;
  localparam int NUM_W  = 48;
  localparam int DEN_W  = 33;
  localparam int CONF_W = 17;

  localparam logic [VAL_W-1:0]  EPSILON_Q = 32'd66;
  localparam logic [CONF_W-1:0] ONE_Q     = 17'h10000;

  // operation codes
  localparam logic [2:0] OP_OFFER    = 3'd0;
  localparam logic [2:0] OP_WITHDRAW = 3'd1;
  localparam logic [2:0] OP_SUBMIT   = 3'd2;
  localparam logic [2:0] OP_SET_REQ  = 3'd3;
  localparam logic [2:0] OP_CANCEL   = 3'd4;
  localparam logic [2:0] OP_SCHEDULE = 3'd5;

  typedef struct packed {
    logic [2:0]       operation;
    logic [3:0]       node;
    logic [1:0]       res_type;
    logic [VAL_W-1:0] capacity;
    logic [VAL_W-1:0] utilization;
    logic [VAL_W-1:0] unit_cost;
    logic [3:0]       task_index;
    logic [VAL_W-1:0] amount;
    logic [15:0]      preferred_mask;
  } req_t;

  typedef struct packed {
    logic              found;
    logic              assigned;
    logic [3:0]        chosen_node;
    logic [SUM_W-1:0]  total_cost;
    logic [CONF_W-1:0] confidence;
    logic [3:0]        echo_task;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic exec;
    logic node_start;
    logic rd;
    logic check;
    logic acc;
    logic nend;
    logic fin;
    logic cdiv;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sched_go;
    logic cand;
    logic need_t;
    logic check_ok;
    logic div_done;
    logic have;
    logic count_zero;
  } sts_t;

  // saturating 48-bit add
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/resource_placement_scorer_unit.sv @@
// ----------------------------------------------------------------------------
// resource_placement_scorer_unit
// Best-fit placement of pending tasks onto nodes offering resources.
// ----------------------------------------------------------------------------
// Takes one item at a time and answers each with exactly one result. Offer,
// withdraw, submit, set-requirement and cancel items are applied in the
// decode state. A schedule request walks every node, steps through each type
// of each candidate node, runs a division per qualifying requirement and then
// one more for the confidence. The walk is paced by the single 48-bit
// restoring divider (one quotient bit per cycle) and the one-read-port offer
// memory that it steps through. A new item is taken while the last result is
// still waiting to be collected.
`default_nettype none

module resource_placement_scorer_unit #(
  parameter int NODE_COUNT = rps_pkg::NODE_COUNT_DEF,
  parameter int TYPE_COUNT = rps_pkg::TYPE_COUNT_DEF,
  parameter int TASK_SLOTS = rps_pkg::TASK_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire rps_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output rps_pkg::rsp_t      rsp
);
  import rps_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int TW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [NW-1:0] n;
  logic [TW-1:0] t;

  rps_ctrl #(
    .NODE_COUNT (NODE_COUNT),
    .TYPE_COUNT (TYPE_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .sts       (sts),
    .cmd       (cmd),
    .n         (n),
    .t         (t)
  );

  rps_datapath #(
    .NODE_COUNT (NODE_COUNT),
    .TYPE_COUNT (TYPE_COUNT),
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .n   (n),
    .t   (t),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

@@ hw/rtl/rps_div.sv @@
// ----------------------------------------------------------------------------
// rps_div
// Restoring divider, one quotient bit per cycle, 48-bit by 33-bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [rps_pkg::NUM_W-1:0] dividend,
  input  wire logic [rps_pkg::DEN_W-1:0] divisor,
  output logic                           done,
  output logic [rps_pkg::NUM_W-1:0]      quotient
);
  import rps_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_shift;
  logic             ge;
  logic [DEN_W:0]   rem_next;

  // one restoring step
  always_comb begin
    rem_shift = {rem, quotient[NUM_W-1]};
    ge        = rem_shift >= {1'b0, den};
    rem_next  = ge ? rem_shift - {1'b0, den} : rem_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= rem_next[DEN_W-1:0];
        quotient <= {quotient[NUM_W-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rps_datapath.sv @@
// ----------------------------------------------------------------------------
// rps_datapath
// Offer and task tables, score and cost accumulation, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_datapath #(
  parameter int NODE_COUNT = rps_pkg::NODE_COUNT_DEF,
  parameter int TYPE_COUNT = rps_pkg::TYPE_COUNT_DEF,
  parameter int TASK_SLOTS = rps_pkg::TASK_SLOTS_DEF,
  localparam int NW = $clog2(NODE_COUNT),
  localparam int TW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rps_pkg::req_t req,
  input  wire rps_pkg::cmd_t cmd,
  input  wire logic [NW-1:0] n,
  input  wire logic [TW-1:0] t,
  output rps_pkg::sts_t      sts,
  output rps_pkg::rsp_t      rsp
);
  import rps_pkg::*;

  localparam int KW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int OFS = NODE_COUNT * TYPE_COUNT;
  localparam int AMS = TASK_SLOTS * TYPE_COUNT;
  localparam int OAW = $clog2(OFS);
  localparam int AAW = (AMS > 1) ? $clog2(AMS) : 1;
  localparam int CW  = $clog2(TYPE_COUNT + 1);

  typedef struct packed {
    logic [VAL_W-1:0] cap;
    logic [VAL_W-1:0] used;
    logic [VAL_W-1:0] cost;
  } offer_t;

  req_t it;

  // table state
  logic [NODE_COUNT-1:0] known;
  logic [OFS-1:0]        present;
  logic [TASK_SLOTS-1:0] pending;
  logic [TYPE_COUNT-1:0] needs   [TASK_SLOTS];
  logic [15:0]           allowed [TASK_SLOTS];
  offer_t                offer_mem [OFS];
  logic [VAL_W-1:0]      amt_mem   [AMS];

  offer_t           offer_q;
  logic [VAL_W-1:0] amt_q;
  logic [63:0]      prod;

  logic [SUM_W-1:0] score;
  logic [SUM_W-1:0] csum;
  logic             have;
  logic [SUM_W-1:0] best;
  logic [SUM_W-1:0] best_cost;
  logic [NW-1:0]    best_node;
  logic             found;
  logic             assigned;
  logic [CONF_W-1:0] conf;

  logic          node_ok, type_ok, task_ok;
  logic [NW-1:0] ni;
  logic [TW-1:0] ti;
  logic [KW-1:0] ki;
  logic [OAW-1:0] oidx_w, oidx_rd;
  logic [AAW-1:0] aidx_w, aidx_rd;
  logic [15:0]    mask;
  logic           allow;
  logic [CW-1:0]  count;
  logic [VAL_W-1:0] freecap;

  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] quo;

  // item decode
  always_comb begin
    node_ok = int'(it.node) < NODE_COUNT;
    type_ok = int'(it.res_type) < TYPE_COUNT;
    task_ok = int'(it.task_index) < TASK_SLOTS;
    ni      = NW'(it.node);
    ti      = TW'(it.res_type);
    ki      = KW'(it.task_index);
    oidx_w  = OAW'(int'(ni) * TYPE_COUNT + int'(ti));
    aidx_w  = AAW'(int'(ki) * TYPE_COUNT + int'(ti));
    oidx_rd = OAW'(int'(n) * TYPE_COUNT + int'(t));
    aidx_rd = AAW'(int'(ki) * TYPE_COUNT + int'(t));
  end

  // mask check of the walked node
  always_comb begin
    mask = allowed[ki];
    if (mask == 16'd0) begin
      allow = 1'b1;
    end else if (int'(n) >= 16) begin
      allow = 1'b0;
    end else begin
      allow = mask[4'(n)];
    end
  end

  // number of required types
  always_comb begin
    count = '0;
    for (int i = 0; i < TYPE_COUNT; i++) begin
      count = count + CW'(needs[ki][i]);
    end
  end

  assign freecap = offer_q.cap - offer_q.used;

  // status
  always_comb begin
    sts.sched_go   = (it.operation == OP_SCHEDULE) && task_ok && pending[ki];
    sts.cand       = known[n] && allow;
    sts.need_t     = needs[ki][t];
    sts.check_ok   = present[oidx_rd] && (offer_q.used <= offer_q.cap) &&
                     (freecap >= amt_q);
    sts.div_done   = div_done;
    sts.have       = have;
    sts.count_zero = (count == '0);
  end

  // divider operands, shared by score terms and confidence
  always_comb begin
    div_start = (cmd.check && sts.check_ok) || (cmd.fin && have && !sts.count_zero);
    if (cmd.fin) begin
      div_num = best;
      div_den = DEN_W'(count);
    end else begin
      div_num = {freecap, 16'd0};
      div_den = {1'b0, amt_q} + {1'b0, EPSILON_Q};
    end
  end

  rps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (quo)
  );

  // memories
  always_ff @(posedge clk) begin
    if (cmd.exec && it.operation == OP_OFFER && node_ok && type_ok) begin
      offer_mem[oidx_w] <= '{cap: it.capacity, used: it.utilization, cost: it.unit_cost};
    end
    if (cmd.rd) begin
      offer_q <= offer_mem[oidx_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && it.operation == OP_SET_REQ && task_ok && type_ok && pending[ki]) begin
      amt_mem[aidx_w] <= it.amount;
    end
    if (cmd.rd) begin
      amt_q <= amt_mem[aidx_rd];
    end
  end

  // table flags
  always_ff @(posedge clk) begin
    if (rst) begin
      known   <= '0;
      present <= '0;
      pending <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        needs[i]   <= '0;
        allowed[i] <= '0;
      end
    end else if (cmd.exec) begin
      unique case (it.operation)
        OP_OFFER: begin
          if (node_ok && type_ok) begin
            known[ni]       <= 1'b1;
            present[oidx_w] <= 1'b1;
          end
        end
        OP_WITHDRAW: begin
          if (node_ok && type_ok) begin
            present[oidx_w] <= 1'b0;
          end
        end
        OP_SUBMIT: begin
          if (task_ok) begin
            pending[ki] <= 1'b1;
            needs[ki]   <= '0;
            allowed[ki] <= it.preferred_mask;
          end
        end
        OP_SET_REQ: begin
          if (task_ok && type_ok && pending[ki]) begin
            needs[ki][ti] <= 1'b1;
          end
        end
        OP_CANCEL: begin
          if (task_ok) begin
            pending[ki] <= 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd.fin && have) begin
      pending[ki] <= 1'b0;
      needs[ki]   <= '0;
    end
  end

  // item capture, accumulation, best tracking, confidence and result load
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it <= req;
    end
    if (cmd.check) begin
      prod <= 64'(offer_q.cost) * 64'(amt_q);
    end
    if (cmd.node_start) begin
      score <= '0;
      csum  <= '0;
    end else if (cmd.acc) begin
      score <= sat_add(score, quo);
      csum  <= sat_add(csum, prod[63:16]);
    end
    if (cmd.nend && (!have || score > best)) begin
      best      <= score;
      best_cost <= csum;
      best_node <= n;
    end
    if (cmd.cdiv) begin
      conf <= (quo > NUM_W'(ONE_Q)) ? ONE_Q : quo[CONF_W-1:0];
    end else if (cmd.fin) begin
      conf <= (have && sts.count_zero) ? ONE_Q : '0;
    end
    if (cmd.load) begin
      rsp.found       <= found;
      rsp.assigned    <= assigned;
      rsp.chosen_node <= assigned ? 4'(best_node) : 4'd0;
      rsp.total_cost  <= assigned ? best_cost : '0;
      rsp.confidence  <= assigned ? conf : '0;
      rsp.echo_task   <= it.task_index;
    end
  end

  // per-item flags
  always_ff @(posedge clk) begin
    if (rst) begin
      have     <= 1'b0;
      found    <= 1'b0;
      assigned <= 1'b0;
    end else if (cmd.exec) begin
      have     <= 1'b0;
      found    <= sts.sched_go;
      assigned <= 1'b0;
    end else begin
      if (cmd.nend) begin
        have <= 1'b1;
      end
      if (cmd.fin) begin
        assigned <= have;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rps_ctrl.sv @@
// ----------------------------------------------------------------------------
// rps_ctrl
// Sequencer: walks nodes and required types for a schedule request.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_ctrl #(
  parameter int NODE_COUNT = rps_pkg::NODE_COUNT_DEF,
  parameter int TYPE_COUNT = rps_pkg::TYPE_COUNT_DEF,
  localparam int NW = $clog2(NODE_COUNT),
  localparam int TW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire logic          rsp_stall,
  output logic               rsp_valid,
  input  wire rps_pkg::sts_t sts,
  output rps_pkg::cmd_t      cmd,
  output logic [NW-1:0]      n,
  output logic [TW-1:0]      t
);
  import rps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_NODE, S_TYPE, S_READ, S_CHECK, S_DIV,
    S_TNEXT, S_NEND, S_NEXT, S_FIN, S_CDIV, S_DONE
  } state_t;

  state_t state;
  logic   rsp_free;

  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // commands decoded from state
  always_comb begin
    cmd.take       = (state == S_IDLE) && req_valid;
    cmd.exec       = (state == S_DECODE);
    cmd.node_start = (state == S_NODE) && sts.cand;
    cmd.rd         = (state == S_TYPE) && sts.need_t;
    cmd.check      = (state == S_CHECK);
    cmd.acc        = (state == S_DIV) && sts.div_done;
    cmd.nend       = (state == S_NEND);
    cmd.fin        = (state == S_FIN);
    cmd.cdiv       = (state == S_CDIV) && sts.div_done;
    cmd.load       = (state == S_DONE) && rsp_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      n         <= '0;
      t         <= '0;
    end else begin
      // result offered on load, dropped once taken
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:   if (req_valid) state <= S_DECODE;
        S_DECODE: begin
          if (sts.sched_go) begin
            n     <= '0;
            state <= S_NODE;
          end else begin
            state <= S_DONE;
          end
        end
        S_NODE: begin
          if (sts.cand) begin
            t     <= '0;
            state <= S_TYPE;
          end else begin
            state <= S_NEXT;
          end
        end
        S_TYPE:   state <= sts.need_t ? S_READ : S_TNEXT;
        S_READ:   state <= S_CHECK;
        S_CHECK:  state <= sts.check_ok ? S_DIV : S_NEXT;
        S_DIV:    if (sts.div_done) state <= S_TNEXT;
        S_TNEXT: begin
          if (t == TW'(TYPE_COUNT - 1)) begin
            state <= S_NEND;
          end else begin
            t     <= t + 1'b1;
            state <= S_TYPE;
          end
        end
        S_NEND:   state <= S_NEXT;
        S_NEXT: begin
          if (n == NW'(NODE_COUNT - 1)) begin
            state <= S_FIN;
          end else begin
            n     <= n + 1'b1;
            state <= S_NODE;
          end
        end
        S_FIN:    state <= (sts.have && !sts.count_zero) ? S_CDIV : S_DONE;
        S_CDIV:   if (sts.div_done) state <= S_DONE;
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rps_checker.sv @@
// ----------------------------------------------------------------------------
// rps_checker
// Port-level checks of the placement scorer results.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire rps_pkg::rsp_t rsp
);
  import rps_pkg::*;

  // a stalled result stays offered and unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result dropped or changed while stalled");

  // one item at a time: input stalls right after an item is taken
  a_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input not stalled after an item");

  // assignment only for a pending task
  a_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> !rsp.assigned)
    else $error("assigned without found");

  // unassigned results carry zeros
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.assigned |->
      rsp.chosen_node == 4'd0 && rsp.total_cost == '0 && rsp.confidence == '0)
    else $error("unassigned result not zero");

  // confidence never above one
  a_conf: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.confidence <= ONE_Q)
    else $error("confidence above one");

endmodule

bind resource_placement_scorer_unit rps_checker u_chk (.*);

`default_nettype wire
